### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication with the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rebt_pkg.sv
`default_nettype none

package rebt_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int ID_W        = 16;
	localparam int TIME_W      = 32;
	localparam int WIN_W       = 16;
	localparam int SLOT_W      = 3;

	// 50 ms blackout after reset
	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd50;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

`default_nettype wire

### rtl/repeat_event_blackout_table.sv
// Channel   | Direction | Signals                       | Transaction
// ----------+-----------+-------------------------------+---------------------------------
// command   | in        | start, busy, event_id, now_ms | start high and busy low at edge
// result    | out       | done, play, slot              | done high for one cycle
// window    | in        | window_valid, window_ready,   | window_valid and window_ready
//           |           | window_ms                     | high at edge
//
// busy stays high while the sequencer reads k entries (k <= ENTRIES + 1), each in a
// state on the read port and a state to check the data, plus a state to write a new id.
// done rises as busy falls and lasts one cycle; the receiver cannot stall, and the
// next command may be taken at the edge that ends the done cycle.
// arst_n clears count and sequencer and sets the window to WINDOW_RESET; the entry memory is not cleared.
`default_nettype none

module repeat_event_blackout_table
	import rebt_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command transaction
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [ID_W-1:0]   event_id,
	input  wire logic [TIME_W-1:0] now_ms,
	// result transaction
	output      logic              done,
	output      logic              play,
	output      logic [SLOT_W-1:0] slot,
	// window register write
	input  wire logic              window_valid,
	output      logic              window_ready,
	input  wire logic [WIN_W-1:0]  window_ms
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_REAP_RD  = 3'd1;  // read the tail entry
	localparam logic [2:0] ST_REAP_CHK = 3'd2;  // drop it if expired
	localparam logic [2:0] ST_SCAN_RD  = 3'd3;  // read entry idx
	localparam logic [2:0] ST_SCAN_CHK = 3'd4;  // compare id, track oldest
	localparam logic [2:0] ST_FINISH   = 3'd5;  // no match: append or replace

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [WIN_W-1:0]  window_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  old_idx_q;
	logic [TIME_W-1:0] old_stamp_q;
	logic              done_q;
	logic              play_q;
	logic [SLOT_W-1:0] slot_q;

	// entry memory: one read port, one write port, registered read data
	entry_t            mem_q [ENTRIES];
	entry_t            rdata_q;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;

	logic [CNT_W-1:0]  count_m1;
	logic [TIME_W-1:0] age;
	logic              expired;
	logic              hit;
	logic              last_entry;
	logic              full;
	logic [IDX_W-1:0]  fin_target;

	assign count_m1   = count_q - CNT_ONE;
	assign age        = now_q - rdata_q.stamp;   // wraps modulo 2^32
	assign expired    = (age >= TIME_W'(window_q));
	assign hit        = (rdata_q.id == id_q);
	assign last_entry = (CNT_W'(idx_q) == count_m1);
	assign full       = (count_q == CNT_FULL);
	assign fin_target = full ? old_idx_q : count_q[IDX_W-1:0];

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		mem_we    = 1'b0;
		mem_waddr = fin_target;
		mem_wdata = '{id: id_q, stamp: now_q};
		unique case (state_q)
			ST_REAP_RD: begin
				mem_re    = 1'b1;
				mem_raddr = count_m1[IDX_W-1:0];
			end
			ST_SCAN_RD: begin
				mem_re = 1'b1;
			end
			ST_SCAN_CHK: begin
				// stale match: refresh its time stamp in place
				mem_we    = hit && expired;
				mem_waddr = idx_q;
			end
			ST_FINISH: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// window register; writes must arrive only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (window_valid && window_ready) begin
			window_q <= window_ms;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						// empty table goes straight to append
						state_q <= (count_q == '0) ? ST_FINISH : ST_REAP_RD;
					end
				end
				ST_REAP_RD: begin
					state_q <= ST_REAP_CHK;
				end
				ST_REAP_CHK: begin
					if (expired) begin
						count_q <= count_m1;
						state_q <= (count_q == CNT_ONE) ? ST_FINISH : ST_REAP_RD;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last_entry) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_FINISH: begin
					if (!full) begin
						count_q <= count_q + CNT_ONE;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					id_q  <= event_id;
					now_q <= now_ms;
				end
			end
			ST_REAP_CHK: begin
				idx_q <= '0;
			end
			ST_SCAN_CHK: begin
				if (hit) begin
					// recent repeat is suppressed with slot 0
					play_q <= expired;
					slot_q <= expired ? SLOT_W'(idx_q) : '0;
				end else begin
					// smallest raw stamp, ties to the lowest index
					if (idx_q == '0 || rdata_q.stamp < old_stamp_q) begin
						old_stamp_q <= rdata_q.stamp;
						old_idx_q   <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_FINISH: begin
				play_q <= 1'b1;
				slot_q <= SLOT_W'(fin_target);
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign window_ready = 1'b1;
	assign done         = done_q;
	assign play         = play_q;
	assign slot         = slot_q;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_count_range, count_q <= CNT_FULL, "entry count above table size")
	`ASSERT_NEXT(a_write_then_done, mem_we, done_q, "table write without a result")
	`ASSERT_CLK(a_done_source, !done_q || $past(state_q) == ST_SCAN_CHK || $past(state_q) == ST_FINISH, "result from a wrong state")
	`ASSERT_CLK(a_suppress_slot, !(done_q && !play_q) || slot_q == '0, "suppressed event with slot")

endmodule

`default_nettype wire

### tb/repeat_event_blackout_table_tb.sv
`default_nettype none

// Self-checking bench for the repeat-event blackout table.
// Commands go in on start/busy, verdicts come back on a one-cycle done strobe.
// A shadow copy of the table is updated on every accepted command. The verdict it
// gives is queued and compared with the next done pulse.
module repeat_event_blackout_table_tb;
	import rebt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	// worst case busy time for one event, plus margin for the done strobe
	localparam int DRAIN_CYCLES = 25;
	localparam int RANDOM_ITEMS = 600;
	localparam int POOL_SIZE    = 10;

	// Verdict of one event: play flag and slot that was used
	typedef struct packed {
		logic              play;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [ID_W-1:0]   event_id;
	logic [TIME_W-1:0] now_ms;
	logic              done;
	logic              play;
	logic [SLOT_W-1:0] slot;
	logic              window_valid;
	logic              window_ready;
	logic [WIN_W-1:0]  window_ms;

	// Shadow table: entries below tbl_count are live
	entry_t            tbl [ENTRIES_DEF];
	int                tbl_count;
	logic [WIN_W-1:0]  blackout_ms;

	verdict_t          verdict_q [$];

	int                cycles;
	int                err_count;
	int                n_events;
	int                n_played;
	int                n_muted;
	int                n_windows;
	int                burst_left;

	repeat_event_blackout_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.event_id     (event_id),
		.now_ms       (now_ms),
		.done         (done),
		.play         (play),
		.slot         (slot),
		.window_valid (window_valid),
		.window_ready (window_ready),
		.window_ms    (window_ms)
	);

	always #10 clk = ~clk;

	// Run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d verdicts still pending", $realtime, verdict_q.size());
			$display("repeat_event_blackout_table_tb: FAIL");
			$finish;
		end
	end

	// Shadow of the table update for one event. Reap stale entries off the tail,
	// then scan in index order; the first id match decides.
	function automatic verdict_t judge_event(logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
		verdict_t         v;
		logic [TIME_W-1:0] age;
		int               oldest;
		int               target;
		bit               hit;

		v      = '0;
		oldest = 0;
		hit    = 1'b0;

		// tail reap; age is modulo 2^32
		while (tbl_count > 0) begin
			age = now - tbl[tbl_count-1].stamp;
			if (age >= TIME_W'(blackout_ms))
				tbl_count--;
			else
				break;
		end

		for (int i = 0; i < tbl_count && !hit; i++) begin
			if (tbl[i].id == id) begin
				hit = 1'b1;
				age = now - tbl[i].stamp;
				if (age >= TIME_W'(blackout_ms)) begin
					// stale match: refresh and let it through
					tbl[i].stamp = now;
					v.play = 1'b1;
					v.slot = SLOT_W'(i);
				end
			end else if (tbl[i].stamp < tbl[oldest].stamp) begin
				// raw compare, strict so ties stay at the lower index
				oldest = i;
			end
		end

		if (!hit) begin
			if (tbl_count < ENTRIES_DEF) begin
				target = tbl_count;
				tbl_count++;
			end else begin
				target = oldest;
			end
			tbl[target].id    = id;
			tbl[target].stamp = now;
			v.play = 1'b1;
			v.slot = SLOT_W'(target);
		end
		return v;
	endfunction

	// Result checker: every done pulse takes the oldest pending verdict
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				err_count++;
				$display("%0t: result with nothing pending: play=%0d slot=%0d",
					$realtime, play, slot);
			end else begin
				exp_v = verdict_q.pop_front();
				if (play !== exp_v.play) begin
					err_count++;
					$display("%0t: play mismatch: expected %0d, actual %0d",
						$realtime, exp_v.play, play);
				end
				if (slot !== exp_v.slot) begin
					err_count++;
					$display("%0t: slot mismatch: expected %0d, actual %0d",
						$realtime, exp_v.slot, slot);
				end
			end
		end
	end

	// One command transaction. start is left high on return so the next
	// event can follow back to back; pace() decides whether to drop it.
	task automatic send_event(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] now);
		verdict_t v;
		@(negedge clk);
		start    <= 1'b1;
		event_id <= id;
		now_ms   <= now;
		@(posedge clk);
		while (busy) @(posedge clk);
		v = judge_event(id, now);
		verdict_q.push_back(v);
		n_events++;
		if (v.play)
			n_played++;
		else
			n_muted++;
	endtask

	// Sender pacing: bursts of random length, then a random gap. The gaps land
	// on every step of the block's scan.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 24);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	// Window write, only once the block has drained. Every event yields a
	// verdict, so an empty queue means the sequencer is idle.
	task automatic set_window(input logic [WIN_W-1:0] w);
		@(negedge clk);
		start <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		window_valid <= 1'b1;
		window_ms    <= w;
		@(posedge clk);
		while (!window_ready) @(posedge clk);
		blackout_ms = w;
		n_windows++;
		@(negedge clk);
		window_valid <= 1'b0;
	endtask

	// Reset window of 50 ms: suppress inside it, reap at exactly the window,
	// refresh a stale match that was not reaped.
	task automatic test_reset_window();
		send_event(16'h0007, 32'd1000);  // new, slot 0
		send_event(16'h0007, 32'd1020);  // repeat inside window
		send_event(16'h0007, 32'd1049);  // one ms short of the window
		send_event(16'h0007, 32'd1050);  // age == window: reaped, appended again
		send_event(16'h0009, 32'd1090);  // second entry, keeps the tail young
		send_event(16'h0007, 32'd1100);  // stale match behind a young tail: refresh
		send_event(16'h0009, 32'd1100);  // young repeat
	endtask

	// Field extremes and a timestamp that wraps through zero
	task automatic test_extremes();
		send_event(16'hFFFF, 32'hFFFF_FFF0);
		send_event(16'h0000, 32'hFFFF_FFFF);
		send_event(16'hFFFF, 32'h0000_0000);  // age across the wrap, suppressed
		send_event(16'h0000, 32'd40);
		send_event(16'hFFFF, 32'd60);         // both reaped across the wrap
	endtask

	// Widest window: fill the table, then force replacement with timestamps tied
	task automatic test_full_table();
		set_window(16'hFFFF);
		for (int i = 0; i < 7; i++)
			send_event(ID_W'(16'h0100 + i), 32'd5000);
		send_event(16'h0200, 32'd5000);   // replaces the older leftover entry
		send_event(16'h0201, 32'd5000);   // all tied: lowest index wins
		send_event(16'h0108, 32'd5001);
	endtask

	// Zero window: everything reaps at once, nothing is ever suppressed
	task automatic test_zero_window();
		set_window(16'h0000);
		send_event(16'h1234, 32'd7000);
		send_event(16'h1234, 32'd7000);
		send_event(16'h1234, 32'd7001);
	endtask

	// Random traffic over several window settings. Mostly a small id pool with
	// short time steps so that the table fills, suppresses and replaces; the rest
	// are long steps across the window and random jumps anywhere in time.
	task automatic test_random_traffic();
		logic [WIN_W-1:0]  windows [7];
		logic [ID_W-1:0]   pool [POOL_SIZE];
		logic [TIME_W-1:0] t;
		logic [ID_W-1:0]   id;
		int                per_phase;
		int                r;

		windows[0] = 16'd1;
		windows[1] = 16'hFFFF;
		windows[2] = 16'd0;
		windows[3] = WIN_W'($urandom_range(0, 65535));
		windows[4] = WIN_W'($urandom_range(0, 65535));
		windows[5] = WINDOW_RESET;
		windows[6] = WIN_W'($urandom_range(1, 200));
		per_phase  = RANDOM_ITEMS / 7 + 1;

		foreach (windows[p]) begin
			set_window(windows[p]);
			foreach (pool[k])
				pool[k] = ID_W'($urandom_range(0, 65535));
			t = $urandom();
			for (int n = 0; n < per_phase; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					t = $urandom();
				else if (r < 15)
					t = t + windows[p] + $urandom_range(0, windows[p]);
				else
					t = t + $urandom_range(0, windows[p] / 8 + 1);
				if ($urandom_range(0, 9) == 0)
					id = ID_W'($urandom_range(0, 65535));
				else
					id = pool[$urandom_range(0, POOL_SIZE - 1)];
				send_event(id, t);
				pace();
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		event_id     = '0;
		now_ms       = '0;
		window_valid = 1'b0;
		window_ms    = '0;
		cycles       = 0;
		err_count    = 0;
		n_events     = 0;
		n_played     = 0;
		n_muted      = 0;
		n_windows    = 0;
		burst_left   = 0;
		tbl_count    = 0;
		blackout_ms  = WINDOW_RESET;
		foreach (tbl[i])
			tbl[i] = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_window();
		test_extremes();
		test_full_table();
		test_zero_window();
		test_random_traffic();

		// drain: last verdicts, then a quiet stretch to catch stray strobes
		@(negedge clk);
		start <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d events (%0d played, %0d suppressed) over %0d window settings",
			n_events, n_played, n_muted, n_windows);
		$display("%0d mismatches in %0d cycles", err_count, cycles);
		if (err_count == 0)
			$display("repeat_event_blackout_table_tb: PASS");
		else
			$display("repeat_event_blackout_table_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
